@@ sv/sltfl_pkg.sv @@
`timescale 1ns / 1ps
// sltfl_pkg: shared constants and codes for the sorted linked table with free list
// used by sorted_linked_table_free_list and its checker; no dependencies

package sltfl_pkg;

    localparam int SLOTS_DEF    = 32;
    localparam int KEY_BITS_DEF = 32;

    typedef enum logic [1:0] {
        FUNC_SEARCH = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_SPARE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_MISSING = 2'd1,
        STAT_PRESENT = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

endpackage

@@ sv/sorted_linked_table_free_list.sv @@
`timescale 1ns / 1ps
// sorted_linked_table_free_list: sorted key chain and free chain in one slot pool
// depends on sltfl_pkg; key and link stores are local synchronous memories
//
//  channel   ports                         handshake
//  -------   ---------------------------   ---------------------------------
//  request   func, key                     taken when start && !busy
//  result    status, slot, prev_slot       valid for one cycle while done
//
// busy covers the walk over the chain entries visited (at most SLOTS) and the
// decision; a successful insert or delete adds a state for the second link write.
// each chain step is one registered read of the link/key memories.
// after reset a clearing pass over all SLOTS entries sets up the free chain; busy is high.
// the receiver cannot stall: done marks the result for exactly one cycle.

module sorted_linked_table_free_list
    import sltfl_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    localparam int SLOT_W  = $clog2(SLOTS + 1),
    localparam int IDX_W   = $clog2(SLOTS)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 func,
    input  logic signed [KEY_BITS-1:0] key,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [SLOT_W-1:0]          slot,
    output logic [SLOT_W-1:0]          prev_slot
);

    localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(SLOTS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DECIDE,
        ST_INS,
        ST_DEL
    } state_t;

    state_t                      state_reg, state_next;
    logic [IDX_W-1:0]            clr_reg, clr_next;
    logic [SLOT_W-1:0]           head_reg, head_next;
    logic [SLOT_W-1:0]           free_reg, free_next;
    logic [SLOT_W-1:0]           cur_reg, cur_next;
    logic [SLOT_W-1:0]           prev_reg, prev_next;
    logic [SLOT_W-1:0]           nxt_reg, nxt_next;
    logic                        found_reg, found_next;
    func_t                       func_reg, func_next;
    logic signed [KEY_BITS-1:0]  key_reg, key_next;
    logic                        done_reg, done_next;
    status_t                     status_reg, status_next;
    logic [SLOT_W-1:0]           slot_reg, slot_next;
    logic [SLOT_W-1:0]           pslot_reg, pslot_next;

    logic [SLOT_W-1:0]           link_mem [SLOTS];
    logic signed [KEY_BITS-1:0]  key_mem [SLOTS];
    logic [SLOT_W-1:0]           link_rdata_reg;
    logic signed [KEY_BITS-1:0]  key_rdata_reg;

    logic [IDX_W-1:0]            rd_addr;
    logic                        lnk_we;
    logic [IDX_W-1:0]            lnk_wa;
    logic [SLOT_W-1:0]           lnk_wd;
    logic                        key_we;

    logic [SLOT_W-1:0]           lnk;
    logic                        head_null;
    logic                        free_null;
    logic                        prev_null;

    assign lnk       = (link_rdata_reg >= NULL_SLOT) ? NULL_SLOT : link_rdata_reg;
    assign head_null = (head_reg >= NULL_SLOT);
    assign free_null = (free_reg >= NULL_SLOT);
    assign prev_null = (prev_reg >= NULL_SLOT);

    // link and key stores
    always_ff @(posedge clk)
    begin
        if (lnk_we)
        begin
            link_mem[lnk_wa] <= lnk_wd;
        end
        if (key_we)
        begin
            key_mem[free_reg[IDX_W-1:0]] <= key_reg;
        end
        link_rdata_reg <= link_mem[rd_addr];
        key_rdata_reg  <= key_mem[rd_addr];
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        head_next   = head_reg;
        free_next   = free_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        nxt_next    = nxt_reg;
        found_next  = found_reg;
        func_next   = func_reg;
        key_next    = key_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        slot_next   = slot_reg;
        pslot_next  = pslot_reg;
        rd_addr     = lnk[IDX_W-1:0];
        lnk_we      = 1'b0;
        lnk_wa      = clr_reg;
        lnk_wd      = NULL_SLOT;
        key_we      = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                lnk_we   = 1'b1;
                lnk_wa   = clr_reg;
                lnk_wd   = SLOT_W'(clr_reg) + SLOT_W'(1);
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                rd_addr = head_reg[IDX_W-1:0];
                if (start)
                begin
                    func_next  = func_t'(func);
                    key_next   = key;
                    prev_next  = NULL_SLOT;
                    found_next = 1'b0;
                    cur_next   = head_null ? NULL_SLOT : head_reg;
                    state_next = head_null ? ST_DECIDE : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (key_rdata_reg >= key_reg)
                begin
                    found_next = (key_rdata_reg == key_reg);
                    nxt_next   = lnk;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = lnk;
                    if (lnk == NULL_SLOT)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                pslot_next = prev_reg;
                state_next = ST_IDLE;
                done_next  = 1'b1;
                case (func_reg)
                    FUNC_INSERT:
                    begin
                        if (found_reg)
                        begin
                            status_next = STAT_PRESENT;
                            slot_next   = cur_reg;
                        end
                        else if (free_null)
                        begin
                            status_next = STAT_FULL;
                            slot_next   = NULL_SLOT;
                        end
                        else
                        begin
                            done_next  = 1'b0;
                            state_next = ST_INS;
                            rd_addr    = free_reg[IDX_W-1:0];
                            key_we     = 1'b1;
                            if (prev_null)
                            begin
                                head_next = free_reg;
                            end
                            else
                            begin
                                lnk_we = 1'b1;
                                lnk_wa = prev_reg[IDX_W-1:0];
                                lnk_wd = free_reg;
                            end
                        end
                    end
                    FUNC_DELETE:
                    begin
                        if (found_reg)
                        begin
                            done_next  = 1'b0;
                            state_next = ST_DEL;
                            if (prev_null)
                            begin
                                head_next = nxt_reg;
                            end
                            else
                            begin
                                lnk_we = 1'b1;
                                lnk_wa = prev_reg[IDX_W-1:0];
                                lnk_wd = nxt_reg;
                            end
                        end
                        else
                        begin
                            status_next = STAT_MISSING;
                            slot_next   = NULL_SLOT;
                        end
                    end
                    default:
                    begin
                        status_next = found_reg ? STAT_OK : STAT_MISSING;
                        slot_next   = found_reg ? cur_reg : NULL_SLOT;
                    end
                endcase
            end
            ST_INS:
            begin
                free_next   = lnk;
                lnk_we      = 1'b1;
                lnk_wa      = free_reg[IDX_W-1:0];
                lnk_wd      = cur_reg;
                done_next   = 1'b1;
                status_next = STAT_OK;
                slot_next   = free_reg;
                state_next  = ST_IDLE;
            end
            ST_DEL:
            begin
                free_next   = cur_reg;
                lnk_we      = 1'b1;
                lnk_wa      = cur_reg[IDX_W-1:0];
                lnk_wd      = free_null ? NULL_SLOT : free_reg;
                done_next   = 1'b1;
                status_next = STAT_OK;
                slot_next   = cur_reg;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            head_reg  <= NULL_SLOT;
            free_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            head_reg  <= head_next;
            free_reg  <= free_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        nxt_reg    <= nxt_next;
        found_reg  <= found_next;
        func_reg   <= func_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        pslot_reg  <= pslot_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;
    assign prev_slot = pslot_reg;

endmodule

@@ sv/sltfl_checker.sv @@
`timescale 1ns / 1ps
// sltfl_checker: port-level checks for sorted_linked_table_free_list, bound to the top
// depends on sltfl_pkg for status codes

module sltfl_checker
    import sltfl_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    localparam int SLOT_W  = $clog2(SLOTS + 1)
)
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [1:0]                 func,
    input logic signed [KEY_BITS-1:0] key,
    input logic                       done,
    input logic [1:0]                 status,
    input logic [SLOT_W-1:0]          slot,
    input logic [SLOT_W-1:0]          prev_slot
);

    localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(SLOTS);

    // an accepted item keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // a result only appears once the block has gone idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result while busy or without preceding item");

    // slot numbers stay in range
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> slot <= NULL_SLOT && prev_slot <= NULL_SLOT)
        else $error("slot out of range");

    // failure codes carry no slot
    a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == STAT_MISSING || status == STAT_FULL) |-> slot == NULL_SLOT)
        else $error("failure result names a slot");

    // success and duplicate codes name a real slot
    a_hit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == STAT_OK || status == STAT_PRESENT) |-> slot < NULL_SLOT)
        else $error("hit result without a slot");

    logic unused_ok;
    assign unused_ok = ^{func, key};

endmodule

bind sorted_linked_table_free_list sltfl_checker #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
) u_sltfl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .key       (key),
    .done      (done),
    .status    (status),
    .slot      (slot),
    .prev_slot (prev_slot)
);

@@ tb/sorted_linked_table_free_list_tb.sv @@
`timescale 1ns / 1ps
// sorted_linked_table_free_list_tb: self-checking bench for the sorted key chain with free list
// depends on sltfl_pkg and sorted_linked_table_free_list; keeps its own copy of both chains
// and checks every result, in order, against it

module sorted_linked_table_free_list_tb;
    import sltfl_pkg::*;

    localparam int SLOTS      = 32;
    localparam int KEY_W      = 32;
    localparam logic [5:0] NO_SLOT = 6'd32;
    localparam int RAND_ITEMS = 1550;
    localparam int PHASE_LEN  = 90;
    localparam int KEY_POOL   = 40;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        func_t                    op;
        logic signed [KEY_W-1:0]  k;
    } request_t;

    typedef struct {
        status_t    st;
        logic [5:0] sl;
        logic [5:0] pv;
    } reply_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic [1:0]              func = FUNC_SEARCH;
    logic signed [KEY_W-1:0] key = '0;
    logic                    busy;
    logic                    done;
    logic [1:0]              status;
    logic [5:0]              slot;
    logic [5:0]              prev_slot;

    request_t pending_reqs[$];
    reply_t   expected_replies[$];

    logic signed [KEY_W-1:0] key_store [SLOTS];
    logic [5:0]              link_store [SLOTS];
    logic [5:0]              chain_head;
    logic [5:0]              free_top;

    logic signed [KEY_W-1:0] key_pool [KEY_POOL];
    int                      issued = 0;
    int                      errors = 0;
    int                      cycles = 0;
    logic                    load_now;
    request_t                next_req;

    sorted_linked_table_free_list u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .key       (key),
        .done      (done),
        .status    (status),
        .slot      (slot),
        .prev_slot (prev_slot)
    );

    always #5 clk = ~clk;

    function automatic logic [5:0] link_after(input logic [5:0] s);
        if (s >= NO_SLOT)
            return NO_SLOT;
        return (link_store[s[4:0]] >= NO_SLOT) ? NO_SLOT : link_store[s[4:0]];
    endfunction

    // walk the sorted chain, update both chains and queue the expected result
    task automatic apply_request(input func_t op, input logic signed [KEY_W-1:0] k);
        logic [5:0] cur;
        logic [5:0] pred;
        logic [5:0] hit;
        logic [5:0] fresh;
        int         steps;
        reply_t     r;
        cur   = (chain_head >= NO_SLOT) ? NO_SLOT : chain_head;
        pred  = NO_SLOT;
        hit   = NO_SLOT;
        steps = 0;
        while (cur < NO_SLOT && steps < SLOTS) begin
            if (key_store[cur[4:0]] >= k)
                break;
            pred  = cur;
            cur   = link_after(cur);
            steps = steps + 1;
        end
        if (cur < NO_SLOT && steps < SLOTS && key_store[cur[4:0]] == k)
            hit = cur;
        r.pv = pred;
        if (op == FUNC_INSERT) begin
            if (hit < NO_SLOT) begin
                r.st = STAT_PRESENT;
                r.sl = hit;
            end
            else if (free_top >= NO_SLOT) begin
                r.st = STAT_FULL;
                r.sl = NO_SLOT;
            end
            else begin
                fresh = free_top;
                free_top = link_after(fresh);
                key_store[fresh[4:0]] = k;
                if (pred < NO_SLOT) begin
                    link_store[fresh[4:0]] = link_after(pred);
                    link_store[pred[4:0]]  = fresh;
                end
                else begin
                    link_store[fresh[4:0]] = (chain_head >= NO_SLOT) ? NO_SLOT : chain_head;
                    chain_head = fresh;
                end
                r.st = STAT_OK;
                r.sl = fresh;
            end
        end
        else if (op == FUNC_DELETE) begin
            if (hit < NO_SLOT) begin
                if (pred < NO_SLOT)
                    link_store[pred[4:0]] = link_after(hit);
                else
                    chain_head = link_after(hit);
                link_store[hit[4:0]] = (free_top >= NO_SLOT) ? NO_SLOT : free_top;
                free_top = hit;
                r.st = STAT_OK;
                r.sl = hit;
            end
            else begin
                r.st = STAT_MISSING;
                r.sl = NO_SLOT;
            end
        end
        else begin
            r.st = (hit < NO_SLOT) ? STAT_OK : STAT_MISSING;
            r.sl = hit;
        end
        expected_replies.push_back(r);
    endtask

    task automatic queue_item(input func_t op, input logic signed [KEY_W-1:0] k);
        request_t q;
        q.op = op;
        q.k  = k;
        pending_reqs.push_back(q);
    endtask

    // driver: one item per handshake, random gaps outside the quiet stretch
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start <= 1'b0;
            func  <= FUNC_SEARCH;
            key   <= '0;
        end
        else begin
            if (start && !busy)
                apply_request(func_t'(func), key);
            load_now = 1'b0;
            if (!(start && busy) && pending_reqs.size() > 0) begin
                if ((issued >= 700 && issued < 1000) || $urandom_range(99) >= 26)
                    load_now = 1'b1;
            end
            if (load_now) begin
                next_req = pending_reqs.pop_front();
                issued   = issued + 1;
                start <= 1'b1;
                func  <= next_req.op;
                key   <= next_req.k;
            end
            else if (!(start && busy)) begin
                start <= 1'b0;
            end
        end
    end

    // monitor: every strobed result against the oldest expectation
    always @(posedge clk) begin
        reply_t want;
        if (rst_n && done) begin
            if (expected_replies.size() == 0) begin
                $error("unexpected result: status %0d slot %0d prev_slot %0d",
                       status, slot, prev_slot);
                errors = errors + 1;
            end
            else begin
                want = expected_replies.pop_front();
                if (status !== want.st) begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    errors = errors + 1;
                end
                if (slot !== want.sl) begin
                    $error("slot: expected %0d, got %0d", want.sl, slot);
                    errors = errors + 1;
                end
                if (prev_slot !== want.pv) begin
                    $error("prev_slot: expected %0d, got %0d", want.pv, prev_slot);
                    errors = errors + 1;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("sorted_linked_table_free_list_tb: errors");
            $finish;
        end
    end

    initial begin
        int    phase;
        int    pick;
        func_t op;
        logic signed [KEY_W-1:0] k;

        for (int i = 0; i < SLOTS; i++) begin
            key_store[i]  = '0;
            link_store[i] = 6'(i + 1);
        end
        chain_head = NO_SLOT;
        free_top   = 6'd0;

        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7fff_ffff;
        key_pool[2] = 32'sd0;
        key_pool[3] = -32'sd1;
        key_pool[4] = 32'sd1;
        for (int i = 5; i < KEY_POOL; i++)
            key_pool[i] = (i % 2) ? $signed(32'($urandom_range(200))) - 32'sd100
                                  : $signed($urandom);

        // empty chain, extremes, duplicate, head/middle/tail removal, slot reuse
        queue_item(FUNC_SEARCH, 32'sd0);
        queue_item(FUNC_DELETE, 32'sd5);
        queue_item(FUNC_INSERT, 32'sd0);
        queue_item(FUNC_INSERT, 32'sh8000_0000);
        queue_item(FUNC_INSERT, 32'sh7fff_ffff);
        queue_item(FUNC_INSERT, -32'sd1);
        queue_item(FUNC_INSERT, 32'sd0);
        queue_item(FUNC_SEARCH, 32'sh8000_0000);
        queue_item(FUNC_SEARCH, 32'sh7fff_ffff);
        queue_item(FUNC_SEARCH, 32'sd7);
        queue_item(FUNC_SPARE, -32'sd1);
        queue_item(FUNC_SPARE, 32'sd3);
        queue_item(FUNC_SEARCH, 32'sh8000_0001);
        queue_item(FUNC_DELETE, 32'sh8000_0000);
        queue_item(FUNC_DELETE, 32'sd0);
        queue_item(FUNC_DELETE, 32'sh7fff_ffff);
        queue_item(FUNC_DELETE, 32'sh7fff_ffff);
        queue_item(FUNC_INSERT, 32'sd100);
        queue_item(FUNC_INSERT, 32'sh8000_0000);
        queue_item(FUNC_INSERT, 32'sh5555_5555);
        queue_item(FUNC_INSERT, -32'sh5555_5556);
        queue_item(FUNC_SEARCH, 32'sd50);

        // alternate filling and draining phases over a small key pool
        for (int i = 0; i < RAND_ITEMS; i++) begin
            phase = (i / PHASE_LEN) % 2;
            pick  = $urandom_range(99);
            if (pick < 5)
                op = FUNC_SPARE;
            else if (pick < 20)
                op = FUNC_SEARCH;
            else if (phase == 0)
                op = (pick < 85) ? FUNC_INSERT : FUNC_DELETE;
            else
                op = (pick < 80) ? FUNC_DELETE : FUNC_INSERT;
            if ($urandom_range(99) < 15)
                k = $signed($urandom);
            else
                k = key_pool[$urandom_range(KEY_POOL - 1)];
            queue_item(op, k);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || start || expected_replies.size() > 0)
            @(posedge clk);
        repeat (SLOTS + 10) @(posedge clk);

        if (errors == 0)
            $display("sorted_linked_table_free_list_tb: clean");
        else
            $display("sorted_linked_table_free_list_tb: errors");
        $finish;
    end

endmodule
